// ----- hw/rtl/ucn_pkg.sv -----
// Types, constants and the look-alike table for the UTF-8 confusable normalizer.
// No dependencies; imported by ucn_fold and utf8_confusable_normalizer.
package ucn_pkg;

  localparam int unsigned MaxRes   = 6;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned GlyphCnt = 16;

  localparam logic [7:0] ByteEf    = 8'hEF;
  localparam logic [7:0] ByteBc    = 8'hBC;
  localparam logic [7:0] ByteBd    = 8'hBD;
  localparam logic [7:0] ByteBb    = 8'hBB;
  localparam logic [7:0] ByteBf    = 8'hBF;
  localparam logic [7:0] ByteE3    = 8'hE3;
  localparam logic [7:0] ByteE2    = 8'hE2;
  localparam logic [7:0] Byte80    = 8'h80;
  localparam logic [7:0] Byte81    = 8'h81;
  localparam logic [7:0] Byte8b    = 8'h8B;
  localparam logic [7:0] Byte8c    = 8'h8C;
  localparam logic [7:0] Byte8d    = 8'h8D;
  localparam logic [7:0] Byte9e    = 8'h9E;
  localparam logic [7:0] ByteAe    = 8'hAE;
  localparam logic [7:0] ByteA0    = 8'hA0;
  localparam logic [7:0] OffsetLo  = 8'h60;
  localparam logic [7:0] OffsetHi  = 8'h20;
  localparam logic [7:0] AsciiSp   = 8'h20;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] CaseDelta = 8'h20;

  typedef struct packed {
    logic [1:0][7:0] wide_hold;
    logic [1:0]      wide_cnt;
    logic [1:0][7:0] zw_hold;
    logic [1:0]      zw_cnt;
    logic            seen_first;
    logic [7:0]      gl_hold;
    logic            gl_vld;
  } ucn_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [ResCntW-1:0]     cnt;
    logic                   bare_end;
  } ucn_res_t;

  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] trail;
    logic [7:0] letter;
  } glyph_t;

  localparam glyph_t GlyphTable [GlyphCnt] = '{
    '{8'hD0, 8'hB0, 8'h61}, '{8'hD0, 8'hB5, 8'h65}, '{8'hD0, 8'hBE, 8'h6F},
    '{8'hD1, 8'h80, 8'h70}, '{8'hD1, 8'h81, 8'h63}, '{8'hD1, 8'h83, 8'h79},
    '{8'hD1, 8'h96, 8'h69}, '{8'hD2, 8'hBB, 8'h68}, '{8'hD1, 8'h85, 8'h78},
    '{8'hD1, 8'h95, 8'h6A}, '{8'hCE, 8'hBF, 8'h6F}, '{8'hCE, 8'hB1, 8'h61},
    '{8'hCE, 8'hBD, 8'h76}, '{8'hCF, 8'h81, 8'h70}, '{8'hCE, 8'hBA, 8'h6B},
    '{8'hCE, 8'hB9, 8'h69}
  };

endpackage

// ----- hw/rtl/ucn_fold.sv -----
// Combinational fold of one byte through the wide-form, lowering, zero-width and look-alike stages.
// Depends on ucn_pkg for the state and result types and the glyph table.
module ucn_fold import ucn_pkg::*; (
  input  ucn_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output ucn_state_t state_o,
  output ucn_res_t   res_o
);

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UpperA && b <= UpperZ) r = b + CaseDelta;
    return r;
  endfunction

  function automatic logic zw_match(input logic [2:0][7:0] w, input logic seen);
    logic m;
    m = 1'b0;
    if (w[0] == ByteE2 && w[1] == Byte80 &&
        (w[2] == Byte8b || w[2] == Byte8c || w[2] == Byte8d || w[2] == ByteAe)) m = 1'b1;
    if (w[0] == ByteE2 && w[1] == Byte81 && w[2] == ByteA0) m = 1'b1;
    if (w[0] == ByteEf && w[1] == ByteBb && w[2] == ByteBf && seen) m = 1'b1;
    return m;
  endfunction

  // {hit, letter}
  function automatic logic [8:0] glyph_lookup(input logic [7:0] lead, input logic [7:0] trail);
    logic [8:0] r;
    r = '0;
    for (int i = GlyphCnt - 1; i >= 0; i--) begin
      if (GlyphTable[i].lead == lead && GlyphTable[i].trail == trail) begin
        r = {1'b1, GlyphTable[i].letter};
      end
    end
    return r;
  endfunction

  logic [2:0][7:0]        w1;
  logic [2:0][7:0]        a;
  logic [1:0]             na;
  logic                   m_bc, m_bd, m_sp;
  logic [2:0][7:0]        zw;
  logic [1:0]             nz;
  logic                   seen;
  logic [MaxRes-1:0][7:0] bq;
  logic [ResCntW-1:0]     nb;
  logic [7:0]             gh;
  logic                   gv;
  logic [8:0]             gl;
  logic [MaxRes-1:0][7:0] cq;
  logic [ResCntW-1:0]     nc;
  logic [1:0][7:0]        wide_hold_n;
  logic [1:0]             wide_cnt_n;
  logic [1:0][7:0]        zw_hold_n;
  logic [1:0]             zw_cnt_n;
  logic                   seen_n;

  // wide-form stage with lowering
  always_comb begin
    w1 = '0;
    w1[0] = state_i.wide_hold[0];
    w1[1] = state_i.wide_hold[1];
    w1[state_i.wide_cnt] = byte_i;
    m_bc = (w1[0] == ByteEf) && (w1[1] == ByteBc) && (w1[2] >= Byte81) && (w1[2] <= ByteBf);
    m_bd = (w1[0] == ByteEf) && (w1[1] == ByteBd) && (w1[2] >= Byte80) && (w1[2] <= Byte9e);
    m_sp = (w1[0] == ByteE3) && (w1[1] == Byte80) && (w1[2] == Byte80);
    a = w1;
    na = 2'd0;
    wide_hold_n[0] = w1[0];
    wide_hold_n[1] = w1[1];
    wide_cnt_n = state_i.wide_cnt + 2'd1;
    if (state_i.wide_cnt == 2'd2) begin
      if (m_bc || m_bd || m_sp) begin
        a[0] = m_bc ? (w1[2] - OffsetLo) : (m_bd ? (w1[2] - OffsetHi) : AsciiSp);
        na = 2'd1;
        wide_cnt_n = 2'd0;
      end else begin
        wide_hold_n[0] = w1[1];
        wide_hold_n[1] = w1[2];
        wide_cnt_n = 2'd2;
        na = end_i ? 2'd3 : 2'd1;
      end
    end else if (end_i) begin
      na = state_i.wide_cnt + 2'd1;
    end
    if (end_i) wide_cnt_n = 2'd0;
    for (int k = 0; k < 3; k++) a[k] = lower_ascii(a[k]);
  end

  // zero-width stage
  always_comb begin
    zw = '0;
    zw[0] = state_i.zw_hold[0];
    zw[1] = state_i.zw_hold[1];
    nz = state_i.zw_cnt;
    seen = state_i.seen_first;
    bq = '0;
    nb = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < na) begin
        zw[nz] = a[k];
        nz = nz + 2'd1;
        if (nz == 2'd3) begin
          if (zw_match(zw, seen)) begin
            nz = 2'd0;
          end else begin
            bq[nb[ResIdxW-1:0]] = zw[0];
            nb = nb + ResCntW'(1);
            zw[0] = zw[1];
            zw[1] = zw[2];
            nz = 2'd2;
          end
          seen = 1'b1;
        end
      end
    end
    if (end_i) begin
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < nz) begin
          bq[nb[ResIdxW-1:0]] = zw[i];
          nb = nb + ResCntW'(1);
        end
      end
    end
    zw_hold_n[0] = zw[0];
    zw_hold_n[1] = zw[1];
    zw_cnt_n = end_i ? 2'd0 : nz;
    seen_n = end_i ? 1'b0 : seen;
  end

  // look-alike stage
  always_comb begin
    gh = state_i.gl_hold;
    gv = state_i.gl_vld;
    gl = '0;
    cq = '0;
    nc = '0;
    for (int k = 0; k < MaxRes - 1; k++) begin
      if (ResCntW'(k) < nb) begin
        if (!gv) begin
          gh = bq[k];
          gv = 1'b1;
        end else begin
          gl = glyph_lookup(gh, bq[k]);
          if (gl[8]) begin
            cq[nc[ResIdxW-1:0]] = gl[7:0];
            gv = 1'b0;
          end else begin
            cq[nc[ResIdxW-1:0]] = gh;
            gh = bq[k];
          end
          nc = nc + ResCntW'(1);
        end
      end
    end
    if (end_i && gv) begin
      cq[nc[ResIdxW-1:0]] = gh;
      nc = nc + ResCntW'(1);
      gv = 1'b0;
    end
    res_o.bytes = cq;
    res_o.cnt = nc;
    res_o.bare_end = 1'b0;
    if (end_i && nc == '0) begin
      res_o.cnt = ResCntW'(1);
      res_o.bare_end = 1'b1;
    end
  end

  assign state_o = {wide_hold_n, wide_cnt_n, zw_hold_n, zw_cnt_n, seen_n, gh, gv};

endmodule

// ----- hw/rtl/utf8_confusable_normalizer.sv -----
// UTF-8 confusable normalizer top level: input register, fold logic, result queue.
// Depends on ucn_pkg and ucn_fold.
// A byte is held in the input register until the result queue empties, then its result is queued for output.
// Throughput: one byte per cycle while the output side takes one beat per cycle.
// An end-of-text byte yields one to six output beats, one per cycle from the result queue.
// rst_ni clears the fold state, the input valid and the queue; input and queued bytes are not.
module utf8_confusable_normalizer import ucn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       byte_valid_o,
  output logic       last_out_o
);

  logic                   s0_vld_q, s0_vld_d;
  logic [7:0]             s0_byte_q;
  logic                   s0_end_q;
  ucn_state_t             st_q, st_d;
  ucn_res_t               fold_res;
  logic [MaxRes-1:0][7:0] res_bytes_q, res_bytes_d;
  logic [ResCntW-1:0]     res_cnt_q, res_cnt_d;
  logic                   res_bare_q, res_bare_d;
  logic                   res_end_q, res_end_d;
  logic                   pop, process, in_acc;
  logic [ResCntW-1:0]     cnt_after_pop;

  ucn_fold u_fold (
    .state_i (st_q),
    .byte_i  (s0_byte_q),
    .end_i   (s0_end_q),
    .state_o (st_d),
    .res_o   (fold_res)
  );

  assign out_valid_o   = (res_cnt_q != '0);
  assign pop           = out_valid_o && !out_stall_i;
  assign cnt_after_pop = res_cnt_q - ResCntW'(pop);
  assign process       = s0_vld_q && (cnt_after_pop == '0);
  assign in_stall_o    = s0_vld_q && !process;
  assign in_acc        = in_valid_i && !in_stall_o;

  assign byte_out_o   = res_bytes_q[0];
  assign byte_valid_o = !res_bare_q;
  assign last_out_o   = res_end_q && (res_cnt_q == ResCntW'(1));

  always_comb begin
    s0_vld_d = s0_vld_q;
    if (process) s0_vld_d = 1'b0;
    if (in_acc) s0_vld_d = 1'b1;
  end

  always_comb begin
    res_bytes_d = res_bytes_q;
    res_cnt_d   = res_cnt_q;
    res_bare_d  = res_bare_q;
    res_end_d   = res_end_q;
    if (process) begin
      res_bytes_d = fold_res.bytes;
      res_cnt_d   = fold_res.cnt;
      res_bare_d  = fold_res.bare_end;
      res_end_d   = s0_end_q;
    end else if (pop) begin
      res_bytes_d = {8'h00, res_bytes_q[MaxRes-1:1]};
      res_cnt_d   = cnt_after_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q   <= 1'b0;
      st_q       <= '0;
      res_cnt_q  <= '0;
      res_bare_q <= 1'b0;
      res_end_q  <= 1'b0;
    end else begin
      s0_vld_q   <= s0_vld_d;
      if (process) st_q <= st_d;
      res_cnt_q  <= res_cnt_d;
      res_bare_q <= res_bare_d;
      res_end_q  <= res_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_byte_q <= byte_in_i;
      s0_end_q  <= end_of_text_i;
    end
    res_bytes_q <= res_bytes_d;
  end

endmodule

// ----- hw/rtl/ucn_checker.sv -----
// Port-level assertions for utf8_confusable_normalizer, attached by bind.
// Depends only on the top level's port list.
module ucn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] byte_in_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_out_o,
  input logic       byte_valid_o,
  input logic       last_out_o
);

  // bare end marker only closes a text and carries a zero byte
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_out_o && (byte_out_o == 8'h00))
    else $error("bare end beat without last or with nonzero byte");

  // lowering precedes every later stage, so no uppercase ASCII leaves
  a_no_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !((byte_out_o >= 8'h41) && (byte_out_o <= 8'h5A)))
    else $error("uppercase ASCII on output");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(byte_out_o) && $stable(byte_valid_o) && $stable(last_out_o))
    else $error("output beat changed while stalled");

endmodule

bind utf8_confusable_normalizer ucn_checker u_ucn_checker (.*);
